@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ hw/rtl/subfm_pkg.sv @@
// Shared types and constants of the substring first-match finder.
package subfm_pkg;

   localparam int PATTERN_MAX_DEF = 8;
   localparam int INDEX_BITS_DEF  = 16;

   localparam int BYTE_W      = 8;
   localparam int PATTERN_W   = 64;
   localparam int LEN_W       = 4;
   localparam int START_W     = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_BYTES  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH = CSR_INDEX_W'(1);

   typedef struct packed {
      logic               hit;
      logic [START_W-1:0] start_index;
      logic               not_found;
      logic               result_last;
   } rsp_type;

endpackage

@@ hw/rtl/substring_first_match_finder.sv @@
// Top level of the streamed substring first-match finder.
// Searches a haystack streamed in one byte per transfer for the first occurrence of a needle of
// 1 to PATTERN_MAX bytes held in pattern_bytes (first needle byte in bits 7:0) and
// pattern_length (0 reads as 1, values above PATTERN_MAX read as PATTERN_MAX). Every haystack
// byte gives one result: hit is raised on the byte that completes the first match and
// start_index then gives the zero-based offset where that match starts (zero otherwise);
// not_found is raised on the last byte when nothing matched; result_last echoes text_last and
// all search state clears after it. Overlapping candidates are all tested. Offsets saturate
// at 2^INDEX_BITS-1, and start_index carries the low 16 bits. Throughput is one byte per clock
// cycle while req_stall is low; a result is registered in the output register, or in the skid
// register if the output stalls. That rate is set by a row of PATTERN_MAX window cells that
// shift the haystack and compare every needle byte in parallel. The result side has an output
// and a skid register, so req_stall comes straight from a flop and rises only once two results
// are waiting. Write the configuration only while the block is idle; csr_ready is always high.
module substring_first_match_finder
   import subfm_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF,
   parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // haystack input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_text_byte,
   input  logic                   req_text_last,
   // results
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_hit,
   output logic [START_W-1:0]     rsp_start_index,
   output logic                   rsp_not_found,
   output logic                   rsp_result_last,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SEEN_W  = $clog2(PATTERN_MAX + 1);
   localparam int START_X = (INDEX_BITS > START_W) ? INDEX_BITS : START_W;

   // configuration registers
   logic [PATTERN_W-1:0] pattern_bytes_ff;
   logic [PATTERN_W-1:0] pattern_bytes_in;
   logic [LEN_W-1:0]     pattern_length_ff;
   logic [LEN_W-1:0]     pattern_length_in;

   // search state
   logic [SEEN_W-1:0]     bytes_seen_ff;
   logic [SEEN_W-1:0]     bytes_seen_in;
   logic [INDEX_BITS-1:0] position_ff;
   logic [INDEX_BITS-1:0] position_in;
   logic                  found_ff;
   logic                  found_in;

   logic                  accept;
   logic [LEN_W-1:0]      active_len;
   logic [SEEN_W-1:0]     seen_inc;
   logic [INDEX_BITS-1:0] pos_inc;
   logic [INDEX_BITS-1:0] back_off;
   logic [INDEX_BITS-1:0] start_pos;
   logic [START_X-1:0]    start_wide;
   logic                  window_match;
   logic                  hit;
   logic                  skid_full;
   rsp_type               result;
   rsp_type               rsp_data;

   logic [BYTE_W-1:0]     win_byte [PATTERN_MAX];
   logic [PATTERN_MAX:0]  match_chain;

   // Configuration port: take every write, drop unknown indexes.
   assign csr_ready = 1'b1;

   always_comb begin
      pattern_bytes_in  = pattern_bytes_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PATTERN_BYTES:  pattern_bytes_in  = csr_data;
            REG_PATTERN_LENGTH: pattern_length_in = csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the programmed length into 1..PATTERN_MAX.
   always_comb begin
      priority if (pattern_length_ff == '0) begin
         active_len = LEN_W'(1);
      end else if (pattern_length_ff > LEN_W'(PATTERN_MAX)) begin
         active_len = LEN_W'(PATTERN_MAX);
      end else begin
         active_len = pattern_length_ff;
      end
   end

   // Input transfer: stall only while the skid register holds a result.
   assign req_stall = skid_full;
   assign accept    = req_valid && !skid_full;

   // Window: cell 0 takes the new byte, each cell hands its byte to the next one.
   // The match flag ripples down the row; cells beyond the needle length pass it.
   assign match_chain[0] = 1'b1;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [BYTE_W-1:0] cell_shift_in;
      if (k == 0) begin : g_head
         assign cell_shift_in = req_text_byte;
      end else begin : g_body
         assign cell_shift_in = win_byte[k-1];
      end
      subfm_cell #(
         .POS(k)
      ) u_cell (
         .clock         (clock),
         .advance       (accept),
         .shift_in      (cell_shift_in),
         .pattern_bytes (pattern_bytes_ff),
         .active_len    (active_len),
         .match_in      (match_chain[k]),
         .byte_out      (win_byte[k]),
         .match_out     (match_chain[k+1])
      );
   end

   // Count bytes up to the window depth and offsets up to all ones.
   assign seen_inc = (bytes_seen_ff < SEEN_W'(PATTERN_MAX)) ?
                     SEEN_W'(bytes_seen_ff + SEEN_W'(1)) : bytes_seen_ff;
   assign pos_inc  = (position_ff != '1) ?
                     INDEX_BITS'(position_ff + INDEX_BITS'(1)) : position_ff;

   // A match needs a full needle's worth of bytes in the window.
   assign window_match = match_chain[PATTERN_MAX] && (LEN_W'(seen_inc) >= active_len);
   assign hit          = window_match && !found_ff;

   // Match start is the current offset less length-1, held at zero below that.
   assign back_off   = INDEX_BITS'(LEN_W'(active_len - LEN_W'(1)));
   assign start_pos  = (position_ff >= back_off) ? INDEX_BITS'(position_ff - back_off) : '0;
   assign start_wide = START_X'(start_pos);

   always_comb begin
      result.hit         = hit;
      result.start_index = hit ? start_wide[START_W-1:0] : '0;
      result.not_found   = req_text_last && !(found_ff || hit);
      result.result_last = req_text_last;
   end

   // Advance the search state on each transfer; clear it after the last byte.
   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      position_in   = position_ff;
      found_in      = found_ff;
      if (accept) begin
         if (req_text_last) begin
            bytes_seen_in = '0;
            position_in   = '0;
            found_in      = 1'b0;
         end else begin
            bytes_seen_in = seen_inc;
            position_in   = pos_inc;
            found_in      = found_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= '0;
         pattern_length_ff <= LEN_W'(1);
         bytes_seen_ff     <= '0;
         position_ff       <= '0;
         found_ff          <= 1'b0;
      end else begin
         pattern_bytes_ff  <= pattern_bytes_in;
         pattern_length_ff <= pattern_length_in;
         bytes_seen_ff     <= bytes_seen_in;
         position_ff       <= position_in;
         found_ff          <= found_in;
      end
   end

   // Result stage: hold results while the consumer stalls.
   subfm_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .full      (skid_full)
   );

   assign rsp_hit         = rsp_data.hit;
   assign rsp_start_index = rsp_data.start_index;
   assign rsp_not_found   = rsp_data.not_found;
   assign rsp_result_last = rsp_data.result_last;

endmodule

@@ hw/rtl/subfm_cell.sv @@
// One window cell: holds one haystack byte, shifts it on, checks it against its needle byte.
module subfm_cell
   import subfm_pkg::*;
#(
   parameter int POS = 0
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [BYTE_W-1:0]    shift_in,
   input  logic [PATTERN_W-1:0] pattern_bytes,
   input  logic [LEN_W-1:0]     active_len,
   input  logic                 match_in,
   output logic [BYTE_W-1:0]    byte_out,
   output logic                 match_out
);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;
   logic [LEN_W-1:0]  needle_sel;
   logic [5:0]        needle_bit;
   logic [BYTE_W-1:0] needle_byte;
   logic              in_use;

   // Newest byte sits in cell 0, so cell POS faces needle byte len-1-POS.
   assign needle_sel  = LEN_W'(active_len - LEN_W'(1) - LEN_W'(POS));
   assign needle_bit  = {needle_sel[2:0], 3'b000};
   assign needle_byte = pattern_bytes[needle_bit +: BYTE_W];
   assign in_use      = active_len > LEN_W'(POS);

   // Compare the value this cell takes on at this transfer.
   assign match_out = match_in && (!in_use || (shift_in == needle_byte));

   assign byte_in  = advance ? shift_in : byte_ff;
   assign byte_out = byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

@@ hw/rtl/subfm_skid.sv @@
// Two-entry result stage: output register plus skid register.
module subfm_skid
   import subfm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   input  logic    out_stall,
   output logic    out_valid,
   output rsp_type out_data,
   output logic    full
);

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    out_free;

   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         // Drain the skid first; a push never comes while the skid is full.
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            if (push) begin
               out_data_in = push_data;
            end
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign full      = skid_valid_ff;

endmodule

@@ hw/rtl/subfm_checker.sv @@
// Port-level assertions for the substring first-match finder, bound to the top level.
`include "assert_macros.svh"

module subfm_checker
   import subfm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_hit,
   input logic [START_W-1:0] rsp_start_index,
   input logic               rsp_not_found,
   input logic               rsp_result_last
);

   `ASSERT_IMPL(a_hit_excl, clock, reset, rsp_valid,
                !(rsp_hit && rsp_not_found), "hit with not_found")
   `ASSERT_IMPL(a_nf_last, clock, reset, rsp_valid && rsp_not_found,
                rsp_result_last, "not_found before last")
   `ASSERT_IMPL(a_idx_zero, clock, reset, rsp_valid && !rsp_hit,
                rsp_start_index == '0, "start_index without hit")
   `ASSERT_IMPL(a_stall_full, clock, reset, req_stall, rsp_valid,
                "input stalled with empty output")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid,
                "stalled result dropped")

endmodule

bind substring_first_match_finder subfm_checker u_subfm_checker (.*);
